FILE: sv/tcba_pkg.sv
package tcba_pkg;

    // pool geometry: block size is a power of two given by its shift
    localparam int SB_SHIFT = 7;
    localparam int SB_N     = 256;
    localparam int BB_SHIFT = 14;
    localparam int BB_N     = 16;

    // index width holds the null code (block count), address width does not
    localparam int SB_IW = $clog2(SB_N + 1);
    localparam int SB_AW = $clog2(SB_N);
    localparam int BB_IW = $clog2(BB_N + 1);
    localparam int BB_AW = $clog2(BB_N);

    localparam logic [31:0] SB_MASK = 32'((64'd1 << SB_SHIFT) - 64'd1);
    localparam logic [31:0] BB_MASK = 32'((64'd1 << BB_SHIFT) - 64'd1);

    localparam logic [31:0] SMALL_BASE_RST = 32'd0;
    localparam logic [31:0] BIG_BASE_RST   = 32'd32768;

    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] CFG_SMALL_BASE = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_BIG_BASE   = 1'b1;

    localparam logic [2:0] CMD_ALLOC_S = 3'd0;
    localparam logic [2:0] CMD_ALLOC_B = 3'd1;
    localparam logic [2:0] CMD_FREE_S  = 3'd2;
    localparam logic [2:0] CMD_FREE_B  = 3'd3;
    localparam logic [2:0] CMD_FREE_E  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_MISAL = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic [31:0] block_address;
        logic [1:0]  status;
    } t_rsp;

    // classified request handed from front to back
    typedef struct packed {
        logic [2:0]       cmd;
        logic [1:0]       s_stat;
        logic [SB_IW-1:0] s_idx;
        logic [1:0]       b_stat;
        logic [BB_IW-1:0] b_idx;
    } t_work;

endpackage

FILE: sv/tcba_ram.sv
module tcba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tcba_front.sv
module tcba_front (
    input  tcba_pkg::t_req  i_req,
    input  logic [31:0]     i_small_base,
    input  logic [31:0]     i_big_base,
    output tcba_pkg::t_work o_work
);

    logic [31:0] s_off;
    logic [31:0] b_off;
    logic [31:0] s_idx;
    logic [31:0] b_idx;

    always_comb begin
        s_off = i_req.address - i_small_base;
        b_off = i_req.address - i_big_base;
        s_idx = s_off >> tcba_pkg::SB_SHIFT;
        b_idx = b_off >> tcba_pkg::BB_SHIFT;

        o_work.cmd   = i_req.command;
        o_work.s_idx = s_idx[tcba_pkg::SB_IW-1:0];
        o_work.b_idx = b_idx[tcba_pkg::BB_IW-1:0];

        // alignment of |off| equals alignment of off in two's complement
        if ((s_off & tcba_pkg::SB_MASK) != 32'd0) begin
            o_work.s_stat = tcba_pkg::ST_MISAL;
        end else if (s_off[31] || (s_idx >= 32'(tcba_pkg::SB_N))) begin
            o_work.s_stat = tcba_pkg::ST_RANGE;
        end else begin
            o_work.s_stat = tcba_pkg::ST_OK;
        end

        if ((b_off & tcba_pkg::BB_MASK) != 32'd0) begin
            o_work.b_stat = tcba_pkg::ST_MISAL;
        end else if (b_off[31] || (b_idx >= 32'(tcba_pkg::BB_N))) begin
            o_work.b_stat = tcba_pkg::ST_RANGE;
        end else begin
            o_work.b_stat = tcba_pkg::ST_OK;
        end
    end

endmodule

FILE: sv/tcba_queue.sv
module tcba_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  tcba_pkg::t_work i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output tcba_pkg::t_work o_data
);

    tcba_pkg::t_work r_ent [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    logic       pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_ent[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wp  = push ? !r_wp : r_wp;
        n_rp  = pop ? !r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= i_data;
        end
    end

endmodule

FILE: sv/tcba_back.sv
module tcba_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  tcba_pkg::t_work i_work,
    input  logic [31:0]     i_small_base,
    input  logic [31:0]     i_big_base,
    output logic            o_valid,
    input  logic            i_stall,
    output tcba_pkg::t_rsp  o_rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP_S = 2'd1;
    localparam logic [1:0] S_POP_B = 2'd2;

    localparam logic [tcba_pkg::SB_IW-1:0] SB_NULL = tcba_pkg::SB_IW'(tcba_pkg::SB_N);
    localparam logic [tcba_pkg::BB_IW-1:0] BB_NULL = tcba_pkg::BB_IW'(tcba_pkg::BB_N);

    logic [1:0] r_state, n_state;
    logic [tcba_pkg::SB_IW-1:0] r_s_head, n_s_head;
    logic [tcba_pkg::BB_IW-1:0] r_b_head, n_b_head;
    logic [tcba_pkg::SB_N-1:0]  r_s_vld, n_s_vld;
    logic [tcba_pkg::BB_N-1:0]  r_b_vld, n_b_vld;
    logic           r_out_valid, n_out_valid;
    tcba_pkg::t_rsp r_out, n_out;

    logic out_free;
    logic take;

    logic                       s_we;
    logic [tcba_pkg::SB_AW-1:0] s_waddr;
    logic [tcba_pkg::SB_IW-1:0] s_rdata;
    logic                       b_we;
    logic [tcba_pkg::BB_AW-1:0] b_waddr;
    logic [tcba_pkg::BB_IW-1:0] b_rdata;

    // links never written since reset read as the next index
    tcba_ram #(.WIDTH(tcba_pkg::SB_IW), .DEPTH(tcba_pkg::SB_N)) u_s_links (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (r_s_head),
        .i_raddr (r_s_head[tcba_pkg::SB_AW-1:0]),
        .o_rdata (s_rdata)
    );

    tcba_ram #(.WIDTH(tcba_pkg::BB_IW), .DEPTH(tcba_pkg::BB_N)) u_b_links (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (r_b_head),
        .i_raddr (r_b_head[tcba_pkg::BB_AW-1:0]),
        .o_rdata (b_rdata)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !(r_state == S_IDLE && out_free);
    assign take     = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_out;
    assign s_waddr  = i_work.s_idx[tcba_pkg::SB_AW-1:0];
    assign b_waddr  = i_work.b_idx[tcba_pkg::BB_AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_s_head    = r_s_head;
        n_b_head    = r_b_head;
        n_s_vld     = r_s_vld;
        n_b_vld     = r_b_vld;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        s_we        = 1'b0;
        b_we        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_out.block_address = 32'd0;
                    n_out.status        = tcba_pkg::ST_OK;
                    n_out_valid         = 1'b1;
                    case (i_work.cmd)
                        tcba_pkg::CMD_ALLOC_S: begin
                            if (r_s_head == SB_NULL) begin
                                n_out.status = tcba_pkg::ST_OOM;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_POP_S;
                            end
                        end
                        tcba_pkg::CMD_ALLOC_B: begin
                            if (r_b_head == BB_NULL) begin
                                n_out.status = tcba_pkg::ST_OOM;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_POP_B;
                            end
                        end
                        tcba_pkg::CMD_FREE_S: begin
                            n_out.status = i_work.s_stat;
                            s_we = (i_work.s_stat == tcba_pkg::ST_OK);
                        end
                        tcba_pkg::CMD_FREE_B: begin
                            n_out.status = i_work.b_stat;
                            b_we = (i_work.b_stat == tcba_pkg::ST_OK);
                        end
                        tcba_pkg::CMD_FREE_E: begin
                            if (i_work.s_stat == tcba_pkg::ST_OK) begin
                                s_we = 1'b1;
                            end else begin
                                n_out.status = i_work.b_stat;
                                b_we = (i_work.b_stat == tcba_pkg::ST_OK);
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (s_we) begin
                        n_s_vld[s_waddr] = 1'b1;
                        n_s_head         = i_work.s_idx;
                    end
                    if (b_we) begin
                        n_b_vld[b_waddr] = 1'b1;
                        n_b_head         = i_work.b_idx;
                    end
                end
            end
            S_POP_S: begin
                n_s_head = r_s_vld[r_s_head[tcba_pkg::SB_AW-1:0]] ? s_rdata
                         : r_s_head + tcba_pkg::SB_IW'(1);
                n_out.block_address = i_small_base
                                    + (32'(r_s_head) << tcba_pkg::SB_SHIFT);
                n_out.status = tcba_pkg::ST_OK;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            S_POP_B: begin
                n_b_head = r_b_vld[r_b_head[tcba_pkg::BB_AW-1:0]] ? b_rdata
                         : r_b_head + tcba_pkg::BB_IW'(1);
                n_out.block_address = i_big_base
                                    + (32'(r_b_head) << tcba_pkg::BB_SHIFT);
                n_out.status = tcba_pkg::ST_OK;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_s_head    <= '0;
            r_b_head    <= '0;
            r_s_vld     <= '0;
            r_b_vld     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_s_head    <= n_s_head;
            r_b_head    <= n_b_head;
            r_s_vld     <= n_s_vld;
            r_b_vld     <= n_b_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

FILE: sv/two_class_block_allocator.sv
// Two-pool fixed-block allocator: a small pool (256 blocks of 128 bytes) and a big pool
// (16 blocks of 16 KiB), each a LIFO free list held in a link RAM plus a head register.
// Requests are classified on entry (offset from the pool base, alignment and range) and
// wait in a two-entry queue until the executing stage takes them; one response comes
// out per request. A free is answered from the idle state; a successful allocate
// goes on to a pop state, since the head's link is read from a synchronous RAM before
// the head can move on. Links are usable straight out of reset with no clearing pass:
// per-entry valid bits make never-written links read as the next block. The user must
// write base registers through the config port (index 0 small base, 1 big base) only
// while no request is in flight, unchecked by the block. Double frees are not detected.
module two_class_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tcba_pkg::t_req                i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tcba_pkg::t_rsp                o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcba_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    logic [31:0] r_small_base;
    logic [31:0] r_big_base;

    tcba_pkg::t_work front_work;
    tcba_pkg::t_work q_work;
    logic            q_valid;
    logic            back_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_base <= tcba_pkg::SMALL_BASE_RST;
            r_big_base   <= tcba_pkg::BIG_BASE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tcba_pkg::CFG_SMALL_BASE: r_small_base <= i_cfg_data;
                tcba_pkg::CFG_BIG_BASE:   r_big_base   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcba_front u_front (
        .i_req        (i_in_data),
        .i_small_base (r_small_base),
        .i_big_base   (r_big_base),
        .o_work       (front_work)
    );

    tcba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (front_work),
        .o_valid (q_valid),
        .i_stall (back_stall),
        .o_data  (q_work)
    );

    tcba_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_stall      (back_stall),
        .i_work       (q_work),
        .i_small_base (r_small_base),
        .i_big_base   (r_big_base),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_rsp        (o_out_data)
    );

endmodule

FILE: tb/sv/tb_two_class_block_allocator.sv
`timescale 1ns / 100ps

module tb_two_class_block_allocator;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int HOLD_CYCLES     = 64;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum {
        SEG_FILL_SMALL, SEG_DRAIN_BIG, SEG_REFILL, SEG_MIXED, SEG_DRAIN_SMALL
    } t_seg_kind;
    typedef enum {ACT_ALLOC_S, ACT_ALLOC_B, ACT_FREE, ACT_NOISE} t_act;

    // tracks both free lists and the responses still owed by the block
    class t_pool_scoreboard;
        logic [31:0]                small_base;
        logic [31:0]                big_base;
        logic [tcba_pkg::SB_IW-1:0] small_link [tcba_pkg::SB_N];
        logic [tcba_pkg::SB_IW-1:0] small_head;
        logic [tcba_pkg::BB_IW-1:0] big_link [tcba_pkg::BB_N];
        logic [tcba_pkg::BB_IW-1:0] big_head;
        tcba_pkg::t_rsp             pending [$];
        int                         mismatches;

        function new();
            small_base = tcba_pkg::SMALL_BASE_RST;
            big_base   = tcba_pkg::BIG_BASE_RST;
            for (int i = 0; i < tcba_pkg::SB_N; i++) small_link[i] = tcba_pkg::SB_IW'(i + 1);
            for (int i = 0; i < tcba_pkg::BB_N; i++) big_link[i] = tcba_pkg::BB_IW'(i + 1);
            small_head = '0;
            big_head   = '0;
            mismatches = 0;
        endfunction

        function tcba_pkg::t_rsp pop_block(bit big);
            tcba_pkg::t_rsp r;
            r = '0;
            if (big) begin
                if (big_head >= tcba_pkg::BB_N) begin
                    r.status = tcba_pkg::ST_OOM;
                end else begin
                    r.block_address = big_base + (32'(big_head) << tcba_pkg::BB_SHIFT);
                    big_head = big_link[big_head];
                end
            end else begin
                if (small_head >= tcba_pkg::SB_N) begin
                    r.status = tcba_pkg::ST_OOM;
                end else begin
                    r.block_address = small_base + (32'(small_head) << tcba_pkg::SB_SHIFT);
                    small_head = small_link[small_head];
                end
            end
            return r;
        endfunction

        function logic [1:0] push_block(bit big, logic [31:0] addr);
            logic [31:0] off;
            logic [31:0] idx;
            off = addr - (big ? big_base : small_base);
            // negating the offset keeps its alignment, so check the raw bits
            if ((off & (big ? tcba_pkg::BB_MASK : tcba_pkg::SB_MASK)) != 32'd0)
                return tcba_pkg::ST_MISAL;
            if (off[31]) return tcba_pkg::ST_RANGE;
            idx = off >> (big ? tcba_pkg::BB_SHIFT : tcba_pkg::SB_SHIFT);
            if (idx >= (big ? tcba_pkg::BB_N : tcba_pkg::SB_N)) return tcba_pkg::ST_RANGE;
            if (big) begin
                big_link[idx] = big_head;
                big_head = tcba_pkg::BB_IW'(idx);
            end else begin
                small_link[idx] = small_head;
                small_head = tcba_pkg::SB_IW'(idx);
            end
            return tcba_pkg::ST_OK;
        endfunction

        function tcba_pkg::t_rsp note_request(logic [2:0] cmd, logic [31:0] addr);
            tcba_pkg::t_rsp r;
            r = '0;
            case (cmd)
                tcba_pkg::CMD_ALLOC_S: r = pop_block(1'b0);
                tcba_pkg::CMD_ALLOC_B: r = pop_block(1'b1);
                tcba_pkg::CMD_FREE_S:  r.status = push_block(1'b0, addr);
                tcba_pkg::CMD_FREE_B:  r.status = push_block(1'b1, addr);
                tcba_pkg::CMD_FREE_E: begin
                    r.status = push_block(1'b0, addr);
                    if (r.status != tcba_pkg::ST_OK) r.status = push_block(1'b1, addr);
                end
                default: ;
            endcase
            pending.push_back(r);
            return r;
        endfunction

        function void check_response(tcba_pkg::t_rsp got);
            tcba_pkg::t_rsp want;
            if (pending.size() == 0) begin
                mismatches++;
                $display("%0t: response with none pending: expected none, got addr %h status %0d",
                         $time, got.block_address, got.status);
                return;
            end
            want = pending.pop_front();
            if (got.block_address !== want.block_address) begin
                mismatches++;
                $display("%0t: block_address expected %h, got %h",
                         $time, want.block_address, got.block_address);
            end
            if (got.status !== want.status) begin
                mismatches++;
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            end
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    tcba_pkg::t_req                i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    tcba_pkg::t_rsp                o_out_data;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [tcba_pkg::CFG_IW-1:0]   i_cfg_index = '0;
    logic [31:0]                   i_cfg_data  = '0;

    t_pool_scoreboard sb;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    int               hold_seq      = 0;
    int               hold_done     = 0;
    t_seg_kind        seg_kind      = SEG_FILL_SMALL;
    int               seg_left      = 290;
    int               live_small [$];
    int               live_big [$];

    two_class_block_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver side: random stall, plus a long hold-off when one is requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_done != hold_seq) begin
                hold_done = hold_seq;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_response(o_out_data);
    end

    function logic [31:0] block_addr(bit big, int idx);
        return (big ? sb.big_base : sb.small_base)
               + (32'(idx) << (big ? tcba_pkg::BB_SHIFT : tcba_pkg::SB_SHIFT));
    endfunction

    // true when a free-either of this address would land in the small pool
    function bit small_claims(logic [31:0] addr);
        logic [31:0] off;
        off = addr - sb.small_base;
        return ((off & tcba_pkg::SB_MASK) == 32'd0)
               && (off < (tcba_pkg::SB_N << tcba_pkg::SB_SHIFT));
    endfunction

    // valid stays high on return so the next request can follow without a gap
    task automatic send_request(input logic [2:0] cmd, input logic [31:0] addr,
                                output tcba_pkg::t_rsp want);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{command: cmd, address: addr};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = sb.note_request(cmd, addr);
    endtask

    task automatic program_bases(input logic [31:0] small_val, input logic [31:0] big_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= tcba_pkg::CFG_SMALL_BASE;
        i_cfg_data  <= small_val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.small_base = small_val;
        i_cfg_index <= tcba_pkg::CFG_BIG_BASE;
        i_cfg_data  <= big_val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.big_base = big_val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random();
        t_act           act;
        int             roll;
        int             pick;
        bit             big;
        logic [2:0]     cmd;
        logic [31:0]    addr;
        tcba_pkg::t_rsp got;
        if (seg_left == 0) begin
            case (seg_kind)
                SEG_DRAIN_BIG: seg_kind = SEG_REFILL;
                SEG_REFILL:    seg_kind = SEG_MIXED;
                SEG_MIXED:     seg_kind = SEG_DRAIN_SMALL;
                default:       seg_kind = SEG_DRAIN_BIG;
            endcase
            seg_left = $urandom_range(110, 30);
        end
        seg_left--;
        roll = $urandom_range(99);
        case (seg_kind)
            SEG_FILL_SMALL:  act = (roll < 95) ? ACT_ALLOC_S : ACT_NOISE;
            SEG_DRAIN_SMALL: act = (roll < 80) ? ACT_ALLOC_S : (roll < 92) ? ACT_FREE : ACT_NOISE;
            SEG_DRAIN_BIG:   act = (roll < 55) ? ACT_ALLOC_B : (roll < 70) ? ACT_ALLOC_S :
                                   (roll < 90) ? ACT_FREE : ACT_NOISE;
            SEG_REFILL:      act = (roll < 75) ? ACT_FREE : (roll < 82) ? ACT_ALLOC_S :
                                   (roll < 88) ? ACT_ALLOC_B : ACT_NOISE;
            default:         act = (roll < 25) ? ACT_ALLOC_S : (roll < 40) ? ACT_ALLOC_B :
                                   (roll < 85) ? ACT_FREE : ACT_NOISE;
        endcase
        if (act == ACT_FREE && live_small.size() == 0 && live_big.size() == 0) act = ACT_ALLOC_S;

        addr = $urandom;
        case (act)
            ACT_ALLOC_S: cmd = tcba_pkg::CMD_ALLOC_S;
            ACT_ALLOC_B: cmd = tcba_pkg::CMD_ALLOC_B;
            ACT_FREE: begin
                if (live_small.size() == 0) big = 1'b1;
                else if (live_big.size() == 0) big = 1'b0;
                else big = 1'($urandom_range(1));
                if (big) begin
                    pick = $urandom_range(live_big.size() - 1);
                    addr = block_addr(1'b1, live_big[pick]);
                    live_big.delete(pick);
                    // free-either only where the small pool turns it down
                    cmd = (!small_claims(addr) && $urandom_range(1) != 0)
                          ? tcba_pkg::CMD_FREE_E : tcba_pkg::CMD_FREE_B;
                end else begin
                    pick = $urandom_range(live_small.size() - 1);
                    addr = block_addr(1'b0, live_small[pick]);
                    live_small.delete(pick);
                    cmd = ($urandom_range(1) != 0) ? tcba_pkg::CMD_FREE_E : tcba_pkg::CMD_FREE_S;
                end
            end
            default: begin
                big  = 1'($urandom_range(1));
                pick = $urandom_range(big ? tcba_pkg::BB_N - 1 : tcba_pkg::SB_N - 1);
                cmd  = big ? tcba_pkg::CMD_FREE_B : tcba_pkg::CMD_FREE_S;
                case ($urandom_range(4))
                    0: addr = block_addr(big, pick)
                              + $urandom_range(big ? tcba_pkg::BB_MASK : tcba_pkg::SB_MASK, 1);
                    1: addr = block_addr(big, (big ? tcba_pkg::BB_N : tcba_pkg::SB_N)
                                              + $urandom_range(999));
                    2: addr = block_addr(big, 0)
                              - (32'($urandom_range(999, 1))
                                 << (big ? tcba_pkg::BB_SHIFT : tcba_pkg::SB_SHIFT));
                    3: cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
                    default: cmd = 3'($urandom_range(7));
                endcase
            end
        endcase

        send_request(cmd, addr, got);
        if (got.status == tcba_pkg::ST_OK && cmd == tcba_pkg::CMD_ALLOC_S)
            live_small.push_back(int'((got.block_address - sb.small_base) >> tcba_pkg::SB_SHIFT));
        if (got.status == tcba_pkg::ST_OK && cmd == tcba_pkg::CMD_ALLOC_B)
            live_big.push_back(int'((got.block_address - sb.big_base) >> tcba_pkg::BB_SHIFT));
    endtask

    initial begin
        tcba_pkg::t_rsp got;
        logic [31:0]    addr;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset bases: small region at 0, big region at 32 KiB
        send_request(tcba_pkg::CMD_ALLOC_S, 32'hFFFF_FFFF, got);
        send_request(tcba_pkg::CMD_ALLOC_B, 32'h0000_0000, got);
        send_request(tcba_pkg::CMD_FREE_S, 32'h0000_0040, got);
        send_request(tcba_pkg::CMD_FREE_S, 32'hFFFF_FF80, got);
        send_request(tcba_pkg::CMD_FREE_S, 32'h0000_8000, got);
        send_request(tcba_pkg::CMD_FREE_S, 32'h8000_0000, got);
        send_request(tcba_pkg::CMD_FREE_S, 32'hFFFF_FFFF, got);
        send_request(tcba_pkg::CMD_FREE_B, 32'h0000_4000, got);
        send_request(tcba_pkg::CMD_FREE_B, 32'h0000_8040, got);
        send_request(tcba_pkg::CMD_FREE_B, 32'h0004_8000, got);
        send_request(tcba_pkg::CMD_FREE_E, 32'h0000_0000, got);
        send_request(tcba_pkg::CMD_FREE_E, 32'h0000_8000, got);
        send_request(tcba_pkg::CMD_FREE_E, 32'h0004_8000, got);
        send_request(tcba_pkg::CMD_FREE_E, 32'h0004_8040, got);
        send_request(CMD_UNUSED_LO, 32'h0000_0000, got);
        send_request(CMD_UNUSED_LO + 3'd1, 32'hFFFF_FFFF, got);
        send_request(CMD_UNUSED_HI, $urandom, got);
        send_request(tcba_pkg::CMD_ALLOC_S, 32'h0000_0000, got);
        send_request(tcba_pkg::CMD_ALLOC_B, 32'h0000_0000, got);
        send_request(tcba_pkg::CMD_FREE_S, 32'h0000_0000, got);
        send_request(tcba_pkg::CMD_FREE_B, 32'h0000_8000, got);
        i_in_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                1: program_bases(32'h0000_0000, 32'hFFFF_FFFF);
                2: program_bases(32'hFFFF_FF80, 32'h8000_0000);
                3: program_bases(32'hFFFF_FFFF, 32'h0000_0000);
                4: program_bases(32'h0001_0000, 32'h0001_0000);
                5: program_bases($urandom, $urandom);
                default: ;
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 57; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 57; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase
            // long receiver hold-off while requests keep coming, so the block backs up
            if (p % 4 == 0) hold_seq++;

            // double free: the same big block is pushed twice and handed out twice
            if (p == N_PHASES - 1) begin
                send_request(tcba_pkg::CMD_ALLOC_B, $urandom, got);
                addr = (got.status == tcba_pkg::ST_OK) ? got.block_address
                                                       : block_addr(1'b1, 0);
                send_request(tcba_pkg::CMD_FREE_B, addr, got);
                send_request(tcba_pkg::CMD_FREE_B, addr, got);
                send_request(tcba_pkg::CMD_ALLOC_B, $urandom, got);
                send_request(tcba_pkg::CMD_ALLOC_B, $urandom, got);
            end

            repeat (ITEMS_PER_PHASE) send_random();
            i_in_valid <= 1'b0;
            wait_drained();
        end

        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/tcba_pkg.sv
sv/tcba_ram.sv
sv/tcba_front.sv
sv/tcba_queue.sv
sv/tcba_back.sv
sv/two_class_block_allocator.sv
tb/sv/tb_two_class_block_allocator.sv
